// ===== src/lfu_pkg.sv =====
// shared types and constants for the lfu cache tracker
package lfu_pkg;

    localparam int DEPTH    = 16;
    localparam int KEY_W    = 32;
    localparam int USE_W    = 16;
    localparam int TOTAL_W  = 32;
    localparam int CAP_W    = 5;
    localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int EXT_W    = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int SCAN_W   = CNT_W;

    localparam logic [EXT_W-1:0] DEPTH_X   = EXT_W'(DEPTH);
    localparam logic [USE_W-1:0] USE_MAX   = {USE_W{1'b1}};
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    // one stored entry, also what a cell hands to its older neighbor
    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [USE_W-1:0] uses;
    } entry_t;

    // running minimum passed down the chain; uses has one extra bit for the start mark
    typedef struct packed {
        logic [USE_W:0]   uses;
        logic [IDX_W-1:0] idx;
        logic [KEY_W-1:0] key;
    } best_t;

    // control broadcast from the sequencer to every cell
    typedef struct packed {
        logic             cmp_en;
        logic             upd_en;
        logic             hit;
        logic [IDX_W-1:0] shift_upto;
        logic [KEY_W-1:0] req_key;
    } cell_ctl_t;

endpackage

// ===== src/lfu_cell.sv =====
// one storage cell: holds an entry, matches the request and forwards the running minimum
module lfu_cell (
    input  logic                    clk,
    input  logic                    rst_n,
    input  lfu_pkg::cell_ctl_t      ctl,
    input  logic [lfu_pkg::IDX_W-1:0] my_idx,
    input  lfu_pkg::entry_t         prev_entry,
    input  lfu_pkg::best_t          best_in,
    output lfu_pkg::entry_t         entry,
    output lfu_pkg::best_t          best_out,
    output logic                    match
);
    import lfu_pkg::*;

    logic             valid_reg;
    logic             valid_next;
    logic [KEY_W-1:0] key_reg;
    logic [KEY_W-1:0] key_next;
    logic [USE_W-1:0] uses_reg;
    logic [USE_W-1:0] uses_next;
    logic             match_reg;
    best_t            best_reg;
    best_t            best_next;

    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        uses_next  = uses_reg;
        if (ctl.upd_en)
        begin
            if (ctl.hit)
            begin
                if (match_reg && (uses_reg != USE_MAX))
                begin
                    uses_next = uses_reg + USE_W'(1);
                end
            end
            else if (my_idx <= ctl.shift_upto)
            begin
                valid_next = prev_entry.valid;
                key_next   = prev_entry.key;
                uses_next  = prev_entry.uses;
            end
        end
    end

    // strict less-than keeps the newer entry on a tie
    always_comb
    begin
        best_next = best_in;
        if (valid_reg && ({1'b0, uses_reg} < best_in.uses))
        begin
            best_next.uses = {1'b0, uses_reg};
            best_next.idx  = my_idx;
            best_next.key  = key_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (ctl.cmp_en)
            begin
                match_reg <= valid_reg && (key_reg == ctl.req_key);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg  <= key_next;
        uses_reg <= uses_next;
        best_reg <= best_next;
    end

    assign entry.valid = valid_reg;
    assign entry.key   = key_reg;
    assign entry.uses  = uses_reg;
    assign best_out    = best_reg;
    assign match       = match_reg;

endmodule

// ===== src/lfu_cache_tracker.sv =====
// top level: request sequencer, totals, output register and the chain of entry cells
// an accepted key passes the states CMP, DEC and UPD, with SCAN before UPD on a miss that evicts,
//   where the minimum-count pass runs down the cell chain; UPD waits for a free output register
// a new key is taken only in IDLE, so one key at a time, and also while a result waits
// reset: asynchronous, active low; store empty, totals zero, capacity 16
module lfu_cache_tracker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [lfu_pkg::CAP_W-1:0]  cfg_data,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [31:0]                s_tdata,   // [31:0] key
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [95:0]                m_tdata,   // [31:0] evicted_key, [63:32] hit_total,
                                                  // [95:64] request_total
    output logic [1:0]                 m_tuser    // [0] hit, [1] evicted_valid
);
    import lfu_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CMP  = 3'd1;
    localparam logic [2:0] S_DEC  = 3'd2;
    localparam logic [2:0] S_SCAN = 3'd3;
    localparam logic [2:0] S_UPD  = 3'd4;

    logic [2:0]         state_reg, state_next;
    logic [CAP_W-1:0]   cap_reg;
    logic [KEY_W-1:0]   req_key_reg;
    logic               hit_reg, hit_next;
    logic               evict_reg, evict_next;
    logic [IDX_W-1:0]   victim_reg, victim_next;
    logic [KEY_W-1:0]   ev_key_reg, ev_key_next;
    logic [SCAN_W-1:0]  scan_cnt_reg, scan_cnt_next;
    logic [CNT_W-1:0]   filled_reg, filled_next;
    logic [TOTAL_W-1:0] hits_reg, hits_next;
    logic [TOTAL_W-1:0] reqs_reg, reqs_next;
    logic               out_valid_reg;
    logic               out_hit_reg;
    logic               out_ev_reg;
    logic [KEY_W-1:0]   out_ev_key_reg;
    logic [TOTAL_W-1:0] out_hits_reg;
    logic [TOTAL_W-1:0] out_reqs_reg;

    logic [EXT_W-1:0]   cap_x, fill_x, eff_cap;
    logic               full;
    logic               any_match;
    logic               out_free;
    logic               do_upd;

    cell_ctl_t          ctl;
    entry_t             new_entry;
    best_t              best_start;
    entry_t             entries [DEPTH];
    best_t              bests   [DEPTH];
    logic [DEPTH-1:0]   match_vec;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign out_free  = !out_valid_reg || m_tready;
    assign do_upd    = (state_reg == S_UPD) && out_free;

    // zero capacity acts as one, anything above the store depth as the depth
    assign cap_x   = EXT_W'(cap_reg);
    assign fill_x  = EXT_W'(filled_reg);
    assign eff_cap = (cap_x == '0) ? EXT_W'(1) : ((cap_x > DEPTH_X) ? DEPTH_X : cap_x);
    assign full    = (fill_x >= eff_cap);
    assign any_match = |match_vec;

    assign new_entry.valid = 1'b1;
    assign new_entry.key   = req_key_reg;
    assign new_entry.uses  = USE_W'(1);

    assign best_start.uses = {1'b1, {USE_W{1'b0}}};
    assign best_start.idx  = '0;
    assign best_start.key  = '0;

    assign ctl.cmp_en     = (state_reg == S_CMP);
    assign ctl.upd_en     = do_upd;
    assign ctl.hit        = hit_reg;
    assign ctl.shift_upto = evict_reg ? victim_reg : IDX_W'(DEPTH - 1);
    assign ctl.req_key    = req_key_reg;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            entry_t prev_e;
            best_t  prev_b;
            if (gi == 0)
            begin : g_head
                assign prev_e = new_entry;
                assign prev_b = best_start;
            end
            else
            begin : g_body
                assign prev_e = entries[gi-1];
                assign prev_b = bests[gi-1];
            end
            lfu_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (ctl),
                .my_idx     (IDX_W'(gi)),
                .prev_entry (prev_e),
                .best_in    (prev_b),
                .entry      (entries[gi]),
                .best_out   (bests[gi]),
                .match      (match_vec[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next    = state_reg;
        hit_next      = hit_reg;
        evict_next    = evict_reg;
        victim_next   = victim_reg;
        ev_key_next   = ev_key_reg;
        scan_cnt_next = scan_cnt_reg;
        filled_next   = filled_reg;
        hits_next     = hits_reg;
        reqs_next     = reqs_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                state_next = S_DEC;
            end
            S_DEC:
            begin
                hit_next    = any_match;
                evict_next  = !any_match && full;
                ev_key_next = '0;
                victim_next = '0;
                scan_cnt_next = '0;
                state_next  = (!any_match && full) ? S_SCAN : S_UPD;
            end
            S_SCAN:
            begin
                // the chain is stable, so its tail holds the minimum once the pass has gone through every cell
                scan_cnt_next = scan_cnt_reg + SCAN_W'(1);
                if (scan_cnt_reg == SCAN_W'(DEPTH - 1))
                begin
                    victim_next = bests[DEPTH-1].idx;
                    ev_key_next = bests[DEPTH-1].key;
                    state_next  = S_UPD;
                end
            end
            S_UPD:
            begin
                if (out_free)
                begin
                    reqs_next = (reqs_reg == TOTAL_MAX) ? reqs_reg : reqs_reg + TOTAL_W'(1);
                    if (hit_reg && (hits_reg != TOTAL_MAX))
                    begin
                        hits_next = hits_reg + TOTAL_W'(1);
                    end
                    if (!hit_reg && !evict_reg)
                    begin
                        filled_next = filled_reg + CNT_W'(1);
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cap_reg       <= CAP_RESET;
            filled_reg    <= '0;
            hits_reg      <= '0;
            reqs_reg      <= '0;
            hit_reg       <= 1'b0;
            evict_reg     <= 1'b0;
            scan_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            filled_reg   <= filled_next;
            hits_reg     <= hits_next;
            reqs_reg     <= reqs_next;
            hit_reg      <= hit_next;
            evict_reg    <= evict_next;
            scan_cnt_reg <= scan_cnt_next;
            if (cfg_valid)
            begin
                cap_reg <= cfg_data;
            end
            if (do_upd)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        victim_reg <= victim_next;
        ev_key_reg <= ev_key_next;
        if (s_tvalid && s_tready)
        begin
            req_key_reg <= s_tdata;
        end
        if (do_upd)
        begin
            out_hit_reg    <= hit_reg;
            out_ev_reg     <= evict_reg;
            out_ev_key_reg <= ev_key_reg;
            out_hits_reg   <= hits_next;
            out_reqs_reg   <= reqs_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reqs_reg, out_hits_reg, out_ev_key_reg};
    assign m_tuser  = {out_ev_reg, out_hit_reg};

endmodule

// ===== test/lfu_cache_tracker_tb.sv =====
// testbench for lfu_cache_tracker: directed and random key streams checked against a software store
module lfu_cache_tracker_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import lfu_pkg::*;

    localparam int           POOL_SIZE   = 24;
    localparam int           QUIET_LIMIT = 2000;
    localparam int           SHOW_LIMIT  = 100;
    localparam logic [4:0]   CAP_FIELD_MAX = 5'd31;

    // one expected lookup outcome
    typedef struct packed {
        logic        hit;
        logic        ev_valid;
        logic [31:0] ev_key;
        logic [31:0] hit_total;
        logic [31:0] req_total;
    } lookup_t;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [CAP_W-1:0]  cfg_data  = '0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [31:0]       s_tdata   = '0;   // [31:0] key
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [95:0]       m_tdata;          // [31:0] evicted_key, [63:32] hit_total,
                                         // [95:64] request_total
    logic [1:0]        m_tuser;          // [0] hit, [1] evicted_valid

    // software copy of the store
    logic              slot_valid [DEPTH];
    logic [KEY_W-1:0]  slot_key   [DEPTH];
    logic [USE_W-1:0]  slot_uses  [DEPTH];
    int                filled_slots = 0;
    logic [31:0]       hit_count    = '0;
    logic [31:0]       req_count    = '0;
    logic [CAP_W-1:0]  capacity     = CAP_RESET;

    lookup_t           pending_lookups [$];
    logic [31:0]       key_pool [POOL_SIZE];

    int                mismatch_count = 0;
    int                quiet_cycles   = 0;
    bit                src_idle_en    = 1'b0;
    bit                sink_stall_en  = 1'b0;

    lfu_cache_tracker dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #10 clk = ~clk;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < SHOW_LIMIT)
            $display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
        mismatch_count++;
    endtask

    // applies one request to the software store and queues what the block should return
    task automatic predict_lookup(input logic [31:0] k);
        lookup_t r;
        int      n;
        int      lim;
        int      victim;
        int      i;
        r = '0;
        n = filled_slots;
        if (capacity == 0)
            lim = 1;
        else if (capacity > DEPTH)
            lim = DEPTH;
        else
            lim = capacity;
        if (req_count != TOTAL_MAX)
            req_count++;
        for (i = 0; i < n; i++) begin
            if (!r.hit && slot_valid[i] && slot_key[i] == k) begin
                r.hit = 1'b1;
                if (slot_uses[i] != USE_MAX)
                    slot_uses[i]++;
            end
        end
        if (r.hit) begin
            if (hit_count != TOTAL_MAX)
                hit_count++;
        end else begin
            if (n >= lim && n > 0) begin
                // lowest count wins, the newest slot on a tie
                victim = 0;
                for (i = 1; i < n; i++)
                    if (slot_uses[i] < slot_uses[victim])
                        victim = i;
                r.ev_valid = 1'b1;
                r.ev_key   = slot_key[victim];
                i = victim;
            end else begin
                i = n;
                filled_slots = n + 1;
            end
            while (i > 0) begin
                slot_valid[i] = slot_valid[i-1];
                slot_key[i]   = slot_key[i-1];
                slot_uses[i]  = slot_uses[i-1];
                i--;
            end
            slot_valid[0] = 1'b1;
            slot_key[0]   = k;
            slot_uses[0]  = 16'd1;
        end
        r.hit_total = hit_count;
        r.req_total = req_count;
        pending_lookups.push_back(r);
    endtask

    // valid stays high after a word so back-to-back words need no second assignment
    task automatic send_key(input logic [31:0] k);
        if (src_idle_en) begin
            while ($urandom_range(99) < 21) begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= k;
        do @(posedge clk); while (!s_tready);
        predict_lookup(k);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending_lookups.size() != 0);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] v);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        capacity = v;
        cfg_valid <= 1'b0;
    endtask

    // result side: random stalls, compare each word with the oldest expectation
    always @(posedge clk) begin
        lookup_t want;
        if (rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
            if (m_tvalid && m_tready) begin
                if (pending_lookups.size() == 0) begin
                    report_mismatch("unexpected word, request_total", m_tdata[95:64], '0);
                end else begin
                    want = pending_lookups.pop_front();
                    if (m_tuser[0] !== want.hit)
                        report_mismatch("hit", 32'(m_tuser[0]), 32'(want.hit));
                    if (m_tuser[1] !== want.ev_valid)
                        report_mismatch("evicted_valid", 32'(m_tuser[1]), 32'(want.ev_valid));
                    if (m_tdata[31:0] !== want.ev_key)
                        report_mismatch("evicted_key", m_tdata[31:0], want.ev_key);
                    if (m_tdata[63:32] !== want.hit_total)
                        report_mismatch("hit_total", m_tdata[63:32], want.hit_total);
                    if (m_tdata[95:64] !== want.req_total)
                        report_mismatch("request_total", m_tdata[95:64], want.req_total);
                end
            end
            m_tready <= !sink_stall_en || ($urandom_range(99) >= 21);
        end
    end

    task automatic test_boundary_keys();
        send_key(32'h0000_0000);
        send_key(32'h7FFF_FFFF);
        send_key(32'h8000_0000);
        send_key(32'hFFFF_FFFF);
        send_key(32'h0000_0000);
        send_key(32'hFFFF_FFFF);
        send_key(32'h8000_0000);
    endtask

    // zero acts as one, so every miss evicts
    task automatic test_capacity_zero_and_one();
        write_capacity('0);
        send_key(32'h0000_0001);
        send_key(32'h0000_0001);
        send_key(32'h0000_0002);
        write_capacity(CAP_W'(1));
        send_key(32'h0000_0003);
    endtask

    task automatic test_tie_goes_to_newest();
        write_capacity(CAP_W'(3));
        send_key(32'h0000_0010);
        send_key(32'h0000_0011);
        send_key(32'h0000_0012);
        send_key(32'h0000_0011);
        send_key(32'h0000_0013);
    endtask

    task automatic test_capacity_above_depth();
        write_capacity(CAP_FIELD_MAX);
        send_key(32'h1000_0001);
        send_key(32'h1000_0002);
        send_key(32'h1000_0003);
        send_key(32'h1000_0004);
    endtask

    // occupancy stays put when capacity drops below it
    task automatic test_capacity_shrink();
        write_capacity(CAP_W'(2));
        send_key(32'h2000_0001);
        send_key(32'h2000_0002);
        send_key(32'h1000_0004);
    endtask

    task automatic test_random_traffic();
        logic [CAP_W-1:0] caps [13];
        logic [31:0]      k;
        int               r;
        int               p;
        int               j;
        caps = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd2, 5'd17, 5'd8, 5'd16, 5'd5, 5'd3,
                 5'd12, 5'd4, 5'd16};
        caps[10] = CAP_W'($urandom_range(1, DEPTH));
        caps[11] = CAP_W'($urandom_range(0, 31));
        for (j = 0; j < POOL_SIZE; j++)
            key_pool[j] = $urandom;
        for (p = 0; p < 13; p++) begin
            // first phase runs with no idling on either side
            src_idle_en   = (p != 0);
            sink_stall_en = (p != 0);
            write_capacity(caps[p]);
            for (j = 0; j < POOL_SIZE; j++)
                if ($urandom_range(1) == 0)
                    key_pool[j] = $urandom;
            for (j = 0; j < 100; j++) begin
                r = $urandom_range(99);
                if (r < 75)
                    k = key_pool[$urandom_range(0, $urandom_range(0, POOL_SIZE - 1))];
                else if (r < 85)
                    case ($urandom_range(3))
                        0:       k = 32'h0000_0000;
                        1:       k = 32'hFFFF_FFFF;
                        2:       k = 32'h8000_0000;
                        default: k = 32'h7FFF_FFFF;
                    endcase
                else
                    k = $urandom;
                send_key(k);
                if ($urandom_range(49) == 0)
                    wait_drained();
            end
        end
    endtask

    initial begin
        for (int i = 0; i < DEPTH; i++)
            slot_valid[i] = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        src_idle_en   = 1'b1;
        sink_stall_en = 1'b1;
        test_boundary_keys();
        test_capacity_zero_and_one();
        test_tie_goes_to_newest();
        test_capacity_above_depth();
        test_capacity_shrink();
        test_random_traffic();
        wait_drained();
        repeat (2 * (DEPTH + 4)) @(posedge clk);
        if (pending_lookups.size() != 0)
            report_mismatch("words never returned", pending_lookups.size(), '0);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
